FILE: rtl/core/ocp_pkg.sv
// Package for the order crossover permutation unit: widths, codes,
// payload and control structs, controller states.
// No dependencies; compile first.
`default_nettype none

package ocp_pkg;

   // Sizes
   localparam int TASK_MAX   = 64;
   localparam int POS_W      = $clog2(TASK_MAX);
   localparam int GENE_W     = 6;
   localparam int PROC_W     = 4;
   localparam int TC_W       = 7;
   localparam int THR_W      = 17;
   localparam int DRAW_W     = 16;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 17;

   // Register reset values (threshold is 0.7 in 16-bit fraction)
   localparam logic [TC_W-1:0]  TC_RESET  = TC_W'(TASK_MAX);
   localparam logic [THR_W-1:0] THR_RESET = 17'd45875;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TASK_COUNT = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 1'b1;

   // Operation codes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_START = 1'b1;

   // One stored parent position
   typedef struct packed {
      logic [GENE_W-1:0] gene_a;
      logic [GENE_W-1:0] gene_b;
      logic [PROC_W-1:0] proc_a;
      logic [PROC_W-1:0] proc_b;
      logic              pick;
   } parent_word_type;

   // Input payload as seen by the datapath
   typedef struct packed {
      logic [POS_W-1:0]  position;
      logic [GENE_W-1:0] order_gene_a;
      logic [GENE_W-1:0] order_gene_b;
      logic [PROC_W-1:0] proc_a;
      logic [PROC_W-1:0] proc_b;
      logic              take_first_proc;
      logic [POS_W-1:0]  cut_first;
      logic [POS_W-1:0]  cut_second;
      logic [DRAW_W-1:0] ox_draw;
   } req_item_type;

   // Result payload
   typedef struct packed {
      logic [POS_W-1:0]  out_position;
      logic [GENE_W-1:0] child_gene;
      logic [PROC_W-1:0] child_proc;
      logic              ox_applied;
      logic              last;
   } rsp_item_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic start;
      logic copy_step;
      logic fill_step;
      logic emit_issue;
      logic emit_adv;
      logic out_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic apply;
      logic copy_last;
      logic fill_last;
      logic fill_full;
      logic out_valid;
      logic out_taken;
      logic out_last;
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COPY,
      ST_FILL,
      ST_DRAIN,
      ST_EMIT_RD,
      ST_EMIT_LD,
      ST_EMIT_OUT
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/core/ocp_if.sv
// Valid/ready channel interfaces for the request and result sides.
// Depends on ocp_pkg for field widths.
`default_nettype none

interface ocp_req_if import ocp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic              operation;
   logic [POS_W-1:0]  position;
   logic [GENE_W-1:0] order_gene_a;
   logic [GENE_W-1:0] order_gene_b;
   logic [PROC_W-1:0] proc_a;
   logic [PROC_W-1:0] proc_b;
   logic              take_first_proc;
   logic [POS_W-1:0]  cut_first;
   logic [POS_W-1:0]  cut_second;
   logic [DRAW_W-1:0] ox_draw;

   modport source (output valid, operation, position, order_gene_a, order_gene_b,
                   proc_a, proc_b, take_first_proc, cut_first, cut_second, ox_draw,
                   input ready);
   modport sink (input valid, operation, position, order_gene_a, order_gene_b,
                 proc_a, proc_b, take_first_proc, cut_first, cut_second, ox_draw,
                 output ready);
endinterface

interface ocp_rsp_if import ocp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [POS_W-1:0]  out_position;
   logic [GENE_W-1:0] child_gene;
   logic [PROC_W-1:0] child_proc;
   logic              ox_applied;
   logic              last;

   modport source (output valid, out_position, child_gene, child_proc, ox_applied, last,
                   input ready);
   modport sink (input valid, out_position, child_gene, child_proc, ox_applied, last,
                 output ready);
endinterface

`default_nettype wire

FILE: rtl/core/ocp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ocp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, old data on a same-address write
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/core/ocp_ctrl.sv
// Controller state machine: sequences load, copy, fill, drain and emit.
// Depends on ocp_pkg; drives the datapath by cmd_type, reads status_type.
`default_nettype none

module ocp_ctrl import ocp_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   input  wire logic       req_op,
   output logic            req_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_op == OP_START) begin
                  cmd.start = 1'b1;
                  state_in  = ST_COPY;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         ST_COPY: begin
            cmd.copy_step = 1'b1;
            if (status.copy_last) begin
               state_in = status.apply ? ST_FILL : ST_DRAIN;
            end
         end
         ST_FILL: begin
            // stop early once every free slot has a gene
            if (status.fill_full) begin
               state_in = ST_DRAIN;
            end else begin
               cmd.fill_step = 1'b1;
               if (status.fill_last) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT_RD;
         end
         ST_EMIT_RD: begin
            cmd.emit_issue = 1'b1;
            state_in       = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            cmd.out_load = 1'b1;
            state_in     = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (status.out_taken) begin
               if (status.out_last) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.emit_adv = 1'b1;
                  state_in     = ST_EMIT_LD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // a result waits in the output register whenever we sit in EMIT_OUT
   a_out_held: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT_OUT) |-> status.out_valid)
      else $error("emit state without a pending result");

   // no result left over when a new item may enter
   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !status.out_valid)
      else $error("result pending while idle");

   // fill pass only runs for an applied crossover
   a_fill_apply: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL) |-> status.apply)
      else $error("fill pass without crossover");

endmodule

`default_nettype wire

FILE: rtl/core/ocp_datapath.sv
// Datapath: config registers, parent and child RAMs, used-gene mask,
// copy/fill/emit pointers and the output register.
// Depends on ocp_pkg and ocp_ram.
`default_nettype none

module ocp_datapath import ocp_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire cmd_type               cmd,
   output status_type                 status,
   input  wire req_item_type          req_item,
   input  wire logic                  rsp_ready,
   output logic                       rsp_valid,
   output rsp_item_type               rsp_item,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   // configuration
   logic [TC_W-1:0]  task_count_ff, task_count_in;
   logic [THR_W-1:0] thresh_ff, thresh_in;

   // per-start values
   logic [POS_W-1:0] t_last_ff, t_last_in;
   logic [POS_W-1:0] c1_ff, c1_in;
   logic [POS_W-1:0] c2_ff, c2_in;
   logic             apply_ff, apply_in;

   // pointers and counters
   logic [POS_W-1:0] copy_ptr_ff, copy_ptr_in;
   logic [POS_W-1:0] copy_addr_ff, copy_addr_in;
   logic             copy_pend_ff, copy_pend_in;
   logic [POS_W-1:0] fill_rd_ff, fill_rd_in;
   logic [POS_W-1:0] fill_k_ff, fill_k_in;
   logic             fill_pend_ff, fill_pend_in;
   logic [POS_W-1:0] widx_ff, widx_in;
   logic [POS_W-1:0] free_ff, free_in;
   logic [POS_W-1:0] emit_ff, emit_in;
   logic [TASK_MAX-1:0] mask_ff, mask_in;

   // output register
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_ff, out_in;

   // start-time derived values
   logic [POS_W-1:0] cut_a, cut_b, lo_cut, hi_cut, free_init, widx_init;
   logic [TC_W-1:0]  tc_dec;

   // RAM ports
   parent_word_type  par_wdata, par_rdata;
   logic [POS_W-1:0] par_raddr, child_raddr, child_waddr;
   logic [GENE_W-1:0] child_wdata, child_rdata;
   logic             child_we;

   logic copy_mark, fill_take, in_seg;

   // effective count minus one, count clamped to 1..TASK_MAX
   assign tc_dec = task_count_ff - TC_W'(1);
   always_comb begin
      if (task_count_ff == '0) begin
         t_last_in = '0;
      end else if (task_count_ff > TC_W'(TASK_MAX)) begin
         t_last_in = POS_W'(TASK_MAX - 1);
      end else begin
         t_last_in = tc_dec[POS_W-1:0];
      end
   end

   // clamp and sort cuts
   always_comb begin
      cut_a     = (req_item.cut_first  > t_last_in) ? t_last_in : req_item.cut_first;
      cut_b     = (req_item.cut_second > t_last_in) ? t_last_in : req_item.cut_second;
      lo_cut    = (cut_a > cut_b) ? cut_b : cut_a;
      hi_cut    = (cut_a > cut_b) ? cut_a : cut_b;
      free_init = t_last_in - (hi_cut - lo_cut);
      widx_init = (hi_cut == t_last_in) ? '0 : hi_cut + POS_W'(1);
   end

   // parent RAM write on load
   always_comb begin
      par_wdata.gene_a = req_item.order_gene_a;
      par_wdata.gene_b = req_item.order_gene_b;
      par_wdata.proc_a = req_item.proc_a;
      par_wdata.proc_b = req_item.proc_b;
      par_wdata.pick   = req_item.take_first_proc;
   end

   // shared parent read address
   always_comb begin
      if (cmd.copy_step) begin
         par_raddr = copy_ptr_ff;
      end else if (cmd.fill_step) begin
         par_raddr = fill_rd_ff;
      end else if (cmd.emit_adv) begin
         par_raddr = emit_ff + POS_W'(1);
      end else begin
         par_raddr = emit_ff;
      end
   end

   assign child_raddr = cmd.emit_adv ? emit_ff + POS_W'(1) : emit_ff;

   // copy and fill decisions on returning read data
   assign in_seg    = (copy_addr_ff >= c1_ff) && (copy_addr_ff <= c2_ff);
   assign copy_mark = copy_pend_ff && apply_ff && in_seg;
   assign fill_take = fill_pend_ff && (free_ff != '0) && !mask_ff[par_rdata.gene_b];

   // child RAM write: copy of parent A, then free slots from parent B
   always_comb begin
      child_we    = copy_pend_ff || fill_take;
      child_waddr = copy_pend_ff ? copy_addr_ff : widx_ff;
      child_wdata = copy_pend_ff ? par_rdata.gene_a : par_rdata.gene_b;
   end

   // next-state logic
   always_comb begin
      task_count_in = task_count_ff;
      thresh_in     = thresh_ff;
      c1_in         = c1_ff;
      c2_in         = c2_ff;
      apply_in      = apply_ff;
      copy_ptr_in   = copy_ptr_ff;
      copy_addr_in  = copy_addr_ff;
      copy_pend_in  = 1'b0;
      fill_rd_in    = fill_rd_ff;
      fill_k_in     = fill_k_ff;
      fill_pend_in  = 1'b0;
      widx_in       = widx_ff;
      free_in       = free_ff;
      emit_in       = emit_ff;
      mask_in       = mask_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;

      // configuration writes
      if (csr_write_en) begin
         case (csr_index)
            CSR_TASK_COUNT: task_count_in = csr_wdata[TC_W-1:0];
            CSR_THRESHOLD:  thresh_in     = csr_wdata[THR_W-1:0];
         endcase
      end

      // start: latch cuts and decision, reset pointers
      if (cmd.start) begin
         c1_in       = lo_cut;
         c2_in       = hi_cut;
         apply_in    = {1'b0, req_item.ox_draw} < thresh_ff;
         copy_ptr_in = '0;
         fill_rd_in  = widx_init;
         fill_k_in   = '0;
         widx_in     = widx_init;
         free_in     = free_init;
         emit_in     = '0;
         mask_in     = '0;
      end

      // copy pass issue
      if (cmd.copy_step) begin
         copy_pend_in = 1'b1;
         copy_addr_in = copy_ptr_ff;
         copy_ptr_in  = copy_ptr_ff + POS_W'(1);
      end

      // fill pass issue, wrapping over the effective count
      if (cmd.fill_step) begin
         fill_pend_in = 1'b1;
         fill_rd_in   = (fill_rd_ff == t_last_ff) ? '0 : fill_rd_ff + POS_W'(1);
         fill_k_in    = fill_k_ff + POS_W'(1);
      end

      // mark genes of the segment and genes taken from parent B
      if (copy_mark) begin
         mask_in[par_rdata.gene_a] = 1'b1;
      end
      if (fill_take) begin
         mask_in[par_rdata.gene_b] = 1'b1;
         widx_in = (widx_ff == t_last_ff) ? '0 : widx_ff + POS_W'(1);
         free_in = free_ff - POS_W'(1);
      end

      // emit pointer
      if (cmd.emit_adv) begin
         emit_in = emit_ff + POS_W'(1);
      end

      // output register
      if (cmd.out_load) begin
         out_valid_in        = 1'b1;
         out_in.out_position = emit_ff;
         out_in.child_gene   = child_rdata;
         out_in.child_proc   = par_rdata.pick ? par_rdata.proc_a : par_rdata.proc_b;
         out_in.ox_applied   = apply_ff;
         out_in.last         = (emit_ff == t_last_ff);
      end else if (out_valid_ff && rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         task_count_ff <= TC_RESET;
         thresh_ff     <= THR_RESET;
         copy_pend_ff  <= 1'b0;
         fill_pend_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
         mask_ff       <= '0;
      end else begin
         task_count_ff <= task_count_in;
         thresh_ff     <= thresh_in;
         copy_pend_ff  <= copy_pend_in;
         fill_pend_ff  <= fill_pend_in;
         out_valid_ff  <= out_valid_in;
         mask_ff       <= mask_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         t_last_ff <= t_last_in;
      end
      c1_ff        <= c1_in;
      c2_ff        <= c2_in;
      apply_ff     <= apply_in;
      copy_ptr_ff  <= copy_ptr_in;
      copy_addr_ff <= copy_addr_in;
      fill_rd_ff   <= fill_rd_in;
      fill_k_ff    <= fill_k_in;
      widx_ff      <= widx_in;
      free_ff      <= free_in;
      emit_ff      <= emit_in;
      out_ff       <= out_in;
   end

   // parent storage: both orders, both processors, pick bit
   ocp_ram #(
      .WIDTH ($bits(parent_word_type)),
      .DEPTH (TASK_MAX)
   ) u_parent_ram (
      .clock   (clock),
      .wr_en   (cmd.load),
      .wr_addr (req_item.position),
      .wr_data (par_wdata),
      .rd_addr (par_raddr),
      .rd_data (par_rdata)
   );

   // child order storage
   ocp_ram #(
      .WIDTH (GENE_W),
      .DEPTH (TASK_MAX)
   ) u_child_ram (
      .clock   (clock),
      .wr_en   (child_we),
      .wr_addr (child_waddr),
      .wr_data (child_wdata),
      .rd_addr (child_raddr),
      .rd_data (child_rdata)
   );

   // status back to the controller
   always_comb begin
      status.apply     = apply_ff;
      status.copy_last = (copy_ptr_ff == t_last_ff);
      status.fill_last = (fill_k_ff == t_last_ff);
      status.fill_full = (free_ff == '0);
      status.out_valid = out_valid_ff;
      status.out_taken = out_valid_ff && rsp_ready;
      status.out_last  = out_ff.last;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_ff;

   // copy and fill writes never land in the same cycle
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      !(copy_pend_ff && fill_pend_ff))
      else $error("copy and fill writes overlap");

   // child reads for emission start only after the last write has landed
   a_drained: assert property (@(posedge clock) disable iff (reset)
      (copy_pend_ff || fill_pend_ff) |-> !(cmd.emit_issue || cmd.emit_adv))
      else $error("child read while a write is pending");

   // each start begins with an empty used-gene mask
   a_mask_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> (mask_ff == '0))
      else $error("used-gene mask not cleared on start");

endmodule

`default_nettype wire

FILE: rtl/core/order_crossover_permutation_unit.sv
// Top level of the order crossover permutation unit.
// Depends on ocp_pkg, ocp_if, ocp_ram, ocp_ctrl and ocp_datapath.
//
//  channel    dir  handshake            carries
//  req_chan   in   valid/ready          load position or start (cuts, draw)
//  rsp_chan   out  valid/ready          one child position per item
//  csr_*      in   write enable only    task_count, crossover_threshold
//
// A start copies parent A over T positions, then walks up to T positions of
// parent B when crossover applies (ends once the free slots are full), then
// passes a drain state and a read setup state, then emits T results, paced
// by the one read port of each RAM.
// Reset is synchronous; RAM contents are undefined until loaded.
// A stalled result holds the output register and the whole unit.
`default_nettype none

module order_crossover_permutation_unit import ocp_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   ocp_req_if.sink                    req_chan,
   ocp_rsp_if.source                  rsp_chan,
   input  wire logic                  csr_write_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type      cmd;
   status_type   status;
   req_item_type req_item;
   rsp_item_type rsp_item;
   logic         req_ready;
   logic         rsp_valid;

   // gather request payload
   always_comb begin
      req_item.position        = req_chan.position;
      req_item.order_gene_a    = req_chan.order_gene_a;
      req_item.order_gene_b    = req_chan.order_gene_b;
      req_item.proc_a          = req_chan.proc_a;
      req_item.proc_b          = req_chan.proc_b;
      req_item.take_first_proc = req_chan.take_first_proc;
      req_item.cut_first       = req_chan.cut_first;
      req_item.cut_second      = req_chan.cut_second;
      req_item.ox_draw         = req_chan.ox_draw;
   end

   assign req_chan.ready = req_ready;

   // drive result channel
   assign rsp_chan.valid        = rsp_valid;
   assign rsp_chan.out_position = rsp_item.out_position;
   assign rsp_chan.child_gene   = rsp_item.child_gene;
   assign rsp_chan.child_proc   = rsp_item.child_proc;
   assign rsp_chan.ox_applied   = rsp_item.ox_applied;
   assign rsp_chan.last         = rsp_item.last;

   ocp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_op    (req_chan.operation),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   ocp_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_item     (req_item),
      .rsp_ready    (rsp_chan.ready),
      .rsp_valid    (rsp_valid),
      .rsp_item     (rsp_item),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

endmodule

`default_nettype wire

FILE: dv/tb_order_crossover_permutation_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for order_crossover_permutation_unit: parent loads,
// order crossover starts and child readout, checked against an in-bench predictor.
// Depends on ocp_pkg, ocp_if and the unit's RTL.

module tb_order_crossover_permutation_unit import ocp_pkg::*; ();

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 400;
   // Parent A order used by the directed rows, position 0 in the low bits
   localparam logic [23:0] DIR_GENES_A = {6'd42, 6'd21, 6'd0, 6'd63};

   // One directed stimulus row; genes/applied are the typed child where typed is set
   typedef struct packed {
      logic              op;
      logic [POS_W-1:0]  pos;
      logic [GENE_W-1:0] gene_a;
      logic [GENE_W-1:0] gene_b;
      logic [PROC_W-1:0] proc_a;
      logic [PROC_W-1:0] proc_b;
      logic              pick;
      logic [POS_W-1:0]  cut_a;
      logic [POS_W-1:0]  cut_b;
      logic [DRAW_W-1:0] draw;
      logic              typed;
      logic [23:0]       genes;
      logic              applied;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   ocp_req_if req_if ();
   ocp_rsp_if rsp_if ();

   order_crossover_permutation_unit uut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_if),
      .rsp_chan     (rsp_if),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   // Predictor state: register copies and parent stores
   logic [TC_W-1:0]   cur_task_count;
   logic [THR_W-1:0]  cur_threshold;
   logic [GENE_W-1:0] par_a_gene [TASK_MAX];
   logic [GENE_W-1:0] par_b_gene [TASK_MAX];
   logic [PROC_W-1:0] par_a_proc [TASK_MAX];
   logic [PROC_W-1:0] par_b_proc [TASK_MAX];
   logic              pick_a     [TASK_MAX];
   bit                loaded     [TASK_MAX];

   rsp_item_type child_due [$];
   rsp_item_type due_item;

   int  send_idle_pct;
   int  recv_idle_pct;
   int  stall_left;
   bit  stall_req;
   int  fail_count;
   int  item_count;
   int  cycle_count;

   // Directed rows: T = 4, threshold left at its reset value
   stim_row_type stim_table [13] = '{
      '{OP_LOAD,  6'd0,  6'd63, 6'd42, 4'd15, 4'd0,  1'b1, 6'd0,  6'd0,  16'd0,
        1'b0, 24'd0, 1'b0},
      '{OP_LOAD,  6'd1,  6'd0,  6'd21, 4'd0,  4'd15, 1'b0, 6'd63, 6'd63, 16'd65535,
        1'b0, 24'd0, 1'b0},
      '{OP_LOAD,  6'd2,  6'd21, 6'd63, 4'd5,  4'd10, 1'b1, 6'd0,  6'd0,  16'd0,
        1'b0, 24'd0, 1'b0},
      '{OP_LOAD,  6'd3,  6'd42, 6'd0,  4'd10, 4'd5,  1'b0, 6'd0,  6'd0,  16'd0,
        1'b0, 24'd0, 1'b0},
      // cuts clamp to the whole range: segment is all of A
      '{OP_START, 6'd0,  6'd0,  6'd0,  4'd0,  4'd0,  1'b0, 6'd0,  6'd63, 16'd45874,
        1'b1, DIR_GENES_A, 1'b1},
      // draw equal to threshold: no crossover
      '{OP_START, 6'd63, 6'd63, 6'd63, 4'd15, 4'd15, 1'b1, 6'd1,  6'd2,  16'd45875,
        1'b1, DIR_GENES_A, 1'b0},
      // reversed cuts
      '{OP_START, 6'd0,  6'd0,  6'd0,  4'd0,  4'd0,  1'b0, 6'd3,  6'd1,  16'd0,
        1'b0, 24'd0, 1'b0},
      // largest draw: no crossover
      '{OP_START, 6'd0,  6'd0,  6'd0,  4'd0,  4'd0,  1'b0, 6'd2,  6'd2,  16'd65535,
        1'b1, DIR_GENES_A, 1'b0},
      '{OP_START, 6'd0,  6'd0,  6'd0,  4'd0,  4'd0,  1'b0, 6'd1,  6'd1,  16'd0,
        1'b0, 24'd0, 1'b0},
      // load past the count in use: stored, not used
      '{OP_LOAD,  6'd63, 6'd63, 6'd63, 4'd15, 4'd15, 1'b1, 6'd0,  6'd0,  16'd0,
        1'b0, 24'd0, 1'b0},
      // parent B no longer a permutation (63 twice)
      '{OP_LOAD,  6'd3,  6'd42, 6'd63, 4'd0,  4'd15, 1'b1, 6'd0,  6'd0,  16'd0,
        1'b0, 24'd0, 1'b0},
      '{OP_START, 6'd0,  6'd0,  6'd0,  4'd0,  4'd0,  1'b0, 6'd0,  6'd1,  16'd100,
        1'b0, 24'd0, 1'b0},
      '{OP_START, 6'd0,  6'd0,  6'd0,  4'd0,  4'd0,  1'b0, 6'd63, 6'd63, 16'd1,
        1'b0, 24'd0, 1'b0}
   };

   // Effective gene count: register clamped to 1..TASK_MAX
   function automatic int tasks_in_use();
      int t;
      t = int'(cur_task_count);
      if (t < 1) t = 1;
      if (t > TASK_MAX) t = TASK_MAX;
      return t;
   endfunction

   function automatic req_item_type rand_item();
      req_item_type it;
      it.position        = POS_W'($urandom_range(63));
      it.order_gene_a    = GENE_W'($urandom_range(63));
      it.order_gene_b    = GENE_W'($urandom_range(63));
      it.proc_a          = PROC_W'($urandom_range(15));
      it.proc_b          = PROC_W'($urandom_range(15));
      it.take_first_proc = 1'($urandom_range(1));
      it.cut_first       = POS_W'($urandom_range(63));
      it.cut_second      = POS_W'($urandom_range(63));
      it.ox_draw         = DRAW_W'($urandom_range(65535));
      return it;
   endfunction

   function automatic void shuffle_ints(inout int vals [TASK_MAX], input int n);
      int j;
      int tmp;
      for (int i = n - 1; i > 0; i--) begin
         j = $urandom_range(i);
         tmp = vals[i];
         vals[i] = vals[j];
         vals[j] = tmp;
      end
   endfunction

   // Child builder: order crossover of the stored parents, queues one item per position
   task automatic breed_child(input logic [POS_W-1:0] cut_a, input logic [POS_W-1:0] cut_b,
                              input logic [DRAW_W-1:0] draw, input bit typed,
                              input logic [23:0] typed_genes, input logic typed_applied);
      int                t, c1, c2, sw, idx, free_left;
      logic [GENE_W-1:0] g;
      bit                apply;
      logic [63:0]       used;
      logic [GENE_W-1:0] child [TASK_MAX];
      rsp_item_type      r;
      t  = tasks_in_use();
      c1 = int'(cut_a);
      c2 = int'(cut_b);
      if (c1 > t - 1) c1 = t - 1;
      if (c2 > t - 1) c2 = t - 1;
      if (c1 > c2) begin
         sw = c1;
         c1 = c2;
         c2 = sw;
      end
      apply = ({1'b0, draw} < cur_threshold);
      used  = '0;
      for (int i = 0; i < t; i++) child[i] = par_a_gene[i];
      if (apply) begin
         for (int i = c1; i <= c2; i++) used[par_a_gene[i]] = 1'b1;
         free_left = t - (c2 - c1 + 1);
         idx = (c2 + 1) % t;
         // walk B from just past the segment, skipping genes already taken
         for (int k = 0; k < t && free_left > 0; k++) begin
            g = par_b_gene[(c2 + 1 + k) % t];
            if (!used[g]) begin
               child[idx] = g;
               used[g] = 1'b1;
               idx = (idx + 1) % t;
               free_left--;
            end
         end
      end
      if (typed) begin
         for (int i = 0; i < 4 && i < t; i++) child[i] = typed_genes[i*6 +: 6];
      end
      for (int i = 0; i < t; i++) begin
         r.out_position = POS_W'(i);
         r.child_gene   = child[i];
         r.child_proc   = pick_a[i] ? par_a_proc[i] : par_b_proc[i];
         r.ox_applied   = typed ? typed_applied : apply;
         r.last         = (i == t - 1);
         child_due.insert(child_due.size(), r);
      end
   endtask

   // Offer one item, wait for the handshake, then update the predictor
   task automatic send_item(input logic op, input req_item_type it, input bit typed,
                            input logic [23:0] typed_genes, input logic typed_applied);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid           <= 1'b1;
      req_if.operation       <= op;
      req_if.position        <= it.position;
      req_if.order_gene_a    <= it.order_gene_a;
      req_if.order_gene_b    <= it.order_gene_b;
      req_if.proc_a          <= it.proc_a;
      req_if.proc_b          <= it.proc_b;
      req_if.take_first_proc <= it.take_first_proc;
      req_if.cut_first       <= it.cut_first;
      req_if.cut_second      <= it.cut_second;
      req_if.ox_draw         <= it.ox_draw;
      do @(posedge clock); while (!req_if.ready);
      item_count++;
      if (op == OP_LOAD) begin
         par_a_gene[it.position] = it.order_gene_a;
         par_b_gene[it.position] = it.order_gene_b;
         par_a_proc[it.position] = it.proc_a;
         par_b_proc[it.position] = it.proc_b;
         pick_a[it.position]     = it.take_first_proc;
         loaded[it.position]     = 1'b1;
      end else begin
         breed_child(it.cut_first, it.cut_second, it.ox_draw, typed, typed_genes,
                     typed_applied);
      end
   endtask

   task automatic load_pos(input int pos, input int gene_a, input int gene_b);
      req_item_type it;
      it = rand_item();
      it.position     = POS_W'(pos);
      it.order_gene_a = GENE_W'(gene_a);
      it.order_gene_b = GENE_W'(gene_b);
      send_item(OP_LOAD, it, 1'b0, '0, 1'b0);
   endtask

   // Start a child; fills any position in use that was never loaded first
   task automatic launch_child();
      req_item_type it;
      int           t;
      int           near;
      t = tasks_in_use();
      for (int p = 0; p < t; p++) begin
         if (!loaded[p]) load_pos(p, $urandom_range(63), $urandom_range(63));
      end
      it = rand_item();
      if ($urandom_range(1) == 1) begin
         it.cut_first  = POS_W'($urandom_range(t - 1));
         it.cut_second = POS_W'($urandom_range(t - 1));
      end
      // draws right at the threshold boundary
      if ($urandom_range(3) == 0) begin
         near = int'(cur_threshold) - 1 + int'($urandom_range(1));
         if (near >= 0 && near <= 65535) it.ox_draw = DRAW_W'(near);
      end
      send_item(OP_START, it, 1'b0, '0, 1'b0);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      if (idx == CSR_TASK_COUNT) cur_task_count = data[TC_W-1:0];
      else cur_threshold = data[THR_W-1:0];
      @(posedge clock);
   endtask

   // Drop valid, wait out every queued child, then let loads settle
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (child_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One random phase at a given setting
   task automatic run_phase(input int tc, input int thr, input int budget,
                            input int s_pct, input int r_pct, input bit hold);
      int first_item;
      int choice;
      int t;
      int i, j, n;
      int ga_i, gb_i, ga_j, gb_j;
      int pool  [TASK_MAX];
      int ord_b [TASK_MAX];
      int slot  [TASK_MAX];
      wait_drained();
      write_csr(CSR_TASK_COUNT, CSR_DATA_W'(tc));
      write_csr(CSR_THRESHOLD, CSR_DATA_W'(thr));
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      if (hold) stall_req = 1'b1;
      t = tasks_in_use();
      first_item = item_count;
      while (item_count - first_item < budget) begin
         choice = $urandom_range(99);
         if (choice < 45) begin
            // fresh parents: distinct genes from the full range, B a reshuffle of A
            for (int k = 0; k < TASK_MAX; k++) pool[k] = k;
            shuffle_ints(pool, TASK_MAX);
            for (int k = 0; k < TASK_MAX; k++) begin
               ord_b[k] = pool[k];
               slot[k]  = k;
            end
            shuffle_ints(ord_b, t);
            shuffle_ints(slot, t);
            for (int k = 0; k < t; k++) load_pos(slot[k], pool[slot[k]], ord_b[slot[k]]);
            launch_child();
         end else if (choice < 70) begin
            // swap two loaded positions in both parents, keeps permutations intact
            i = $urandom_range(t - 1);
            j = $urandom_range(t - 1);
            if (loaded[i] && loaded[j]) begin
               ga_i = int'(par_a_gene[i]);
               gb_i = int'(par_b_gene[i]);
               ga_j = int'(par_a_gene[j]);
               gb_j = int'(par_b_gene[j]);
               load_pos(i, ga_j, gb_j);
               load_pos(j, ga_i, gb_i);
            end
            launch_child();
         end else if (choice < 85) begin
            // noise loads anywhere, parents may break
            n = $urandom_range(4, 1);
            for (int k = 0; k < n; k++)
               load_pos($urandom_range(63), $urandom_range(63), $urandom_range(63));
            launch_child();
         end else begin
            launch_child();
         end
      end
   endtask

   // Result side: check accepted items, drive ready with idling and hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (child_due.size() == 0) begin
               $error("child item with none expected: position %0d", rsp_if.out_position);
               fail_count++;
            end else begin
               due_item = child_due.pop_front();
               if (rsp_if.out_position !== due_item.out_position) begin
                  $error("out_position: expected %0d, actual %0d",
                         due_item.out_position, rsp_if.out_position);
                  fail_count++;
               end
               if (rsp_if.child_gene !== due_item.child_gene) begin
                  $error("child_gene: expected %0d, actual %0d",
                         due_item.child_gene, rsp_if.child_gene);
                  fail_count++;
               end
               if (rsp_if.child_proc !== due_item.child_proc) begin
                  $error("child_proc: expected %0d, actual %0d",
                         due_item.child_proc, rsp_if.child_proc);
                  fail_count++;
               end
               if (rsp_if.ox_applied !== due_item.ox_applied) begin
                  $error("ox_applied: expected %0d, actual %0d",
                         due_item.ox_applied, rsp_if.ox_applied);
                  fail_count++;
               end
               if (rsp_if.last !== due_item.last) begin
                  $error("last: expected %0d, actual %0d", due_item.last, rsp_if.last);
                  fail_count++;
               end
            end
         end
         if (stall_req) begin
            stall_left = HOLD_CYCLES;
            stall_req  = 1'b0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Stimulus sequence
   initial begin
      req_if.valid           = 1'b0;
      req_if.operation       = OP_LOAD;
      req_if.position        = '0;
      req_if.order_gene_a    = '0;
      req_if.order_gene_b    = '0;
      req_if.proc_a          = '0;
      req_if.proc_b          = '0;
      req_if.take_first_proc = 1'b0;
      req_if.cut_first       = '0;
      req_if.cut_second      = '0;
      req_if.ox_draw         = '0;
      csr_write_en           = 1'b0;
      csr_index              = CSR_TASK_COUNT;
      csr_wdata              = '0;
      cur_task_count         = TC_RESET;
      cur_threshold          = THR_RESET;
      send_idle_pct          = 8;
      recv_idle_pct          = 64;
      stall_req              = 1'b0;
      stall_left             = 0;
      fail_count             = 0;
      item_count             = 0;
      cycle_count            = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed rows
      write_csr(CSR_TASK_COUNT, CSR_DATA_W'(4));
      foreach (stim_table[n]) begin
         req_item_type it;
         it.position        = stim_table[n].pos;
         it.order_gene_a    = stim_table[n].gene_a;
         it.order_gene_b    = stim_table[n].gene_b;
         it.proc_a          = stim_table[n].proc_a;
         it.proc_b          = stim_table[n].proc_b;
         it.take_first_proc = stim_table[n].pick;
         it.cut_first       = stim_table[n].cut_a;
         it.cut_second      = stim_table[n].cut_b;
         it.ox_draw         = stim_table[n].draw;
         send_item(stim_table[n].op, it, stim_table[n].typed, stim_table[n].genes,
                   stim_table[n].applied);
      end

      // Random phases: count 0 and 127 clamp, threshold never/always/boundary
      run_phase(6,   45875,  55, 8,  64, 1'b0);
      run_phase(0,   131071, 25, 8,  64, 1'b0);
      run_phase(13,  32768,  55, 64, 8,  1'b1);
      run_phase(64,  65536,  85, 64, 8,  1'b0);
      run_phase(2,   0,      30, 0,  0,  1'b0);
      run_phase(127, 1,      45, 0,  0,  1'b0);
      wait_drained();

      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

FILE: order_crossover_permutation_unit.f
rtl/core/ocp_pkg.sv
rtl/core/ocp_if.sv
rtl/core/ocp_ram.sv
rtl/core/ocp_ctrl.sv
rtl/core/ocp_datapath.sv
rtl/core/order_crossover_permutation_unit.sv
dv/tb_order_crossover_permutation_unit.sv
